/* rtl/tnsg_pkg.sv */
package tnsg_pkg;

    // field and register widths
    localparam int RATE_W     = 18;
    localparam int FREQ_W     = 16;
    localparam int LEVEL_W    = 17;
    localparam int GAIN_W     = 17;
    localparam int FMT_W      = 3;
    localparam int DRAW_W     = 24;
    localparam int CODE_W     = 24;
    localparam int CFG_DATA_W = RATE_W;
    localparam int CFG_IDX_W  = 3;

    // sine table and mix format
    localparam int SINE_TABLE_BITS = 10;
    localparam int MIX_FRAC_BITS   = 22;
    localparam int MIX_W           = MIX_FRAC_BITS + 2;
    localparam int SINE_MAG_W      = MIX_FRAC_BITS + 1;
    localparam int QIDX_W          = SINE_TABLE_BITS - 2;
    localparam int QUARTER         = 1 << QIDX_W;

    // phase divider
    localparam int DIV_STEPS = RATE_W + SINE_TABLE_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // shared multiplier
    localparam int GAIN_SHIFT  = 16;
    localparam int MUL_W       = (MIX_W > CODE_W) ? MIX_W : CODE_W;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int NOISE_SHIFT = DRAW_W - MIX_FRAC_BITS;

    localparam logic [GAIN_W-1:0]     GAIN_ONE = GAIN_W'(65536);
    localparam logic [SINE_MAG_W-1:0] SINE_ONE = SINE_MAG_W'(1) << MIX_FRAC_BITS;
    localparam logic [MIX_W-1:0]      MIX_ONE  = MIX_W'(1) << MIX_FRAC_BITS;
    localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;

    // quantizer full scales
    localparam logic [MUL_W-1:0] MAX_U8  = MUL_W'(255);
    localparam logic [MUL_W-1:0] MAX_S8  = MUL_W'(127);
    localparam logic [MUL_W-1:0] MAX_U16 = MUL_W'(65535);
    localparam logic [MUL_W-1:0] MAX_S16 = MUL_W'(32767);
    localparam logic [MUL_W-1:0] MAX_U24 = MUL_W'(16777215);
    localparam logic [MUL_W-1:0] MAX_S24 = MUL_W'(8388607);

    // sample formats
    localparam logic [FMT_W-1:0] FMT_U8  = FMT_W'(0);
    localparam logic [FMT_W-1:0] FMT_S8  = FMT_W'(1);
    localparam logic [FMT_W-1:0] FMT_U16 = FMT_W'(2);
    localparam logic [FMT_W-1:0] FMT_S16 = FMT_W'(3);
    localparam logic [FMT_W-1:0] FMT_U24 = FMT_W'(4);
    localparam logic [FMT_W-1:0] FMT_S24 = FMT_W'(5);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQUENCY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT  = CFG_IDX_W'(4);

    // register reset values
    localparam logic [FREQ_W-1:0]  FREQ_RST  = FREQ_W'(900);
    localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(48000);
    localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(0);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_ONE;
    localparam logic [FMT_W-1:0]   FMT_RST   = FMT_S16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_PHASE,
        ST_TONE_MUL,
        ST_TONE_WB,
        ST_NOISE_MUL,
        ST_NOISE_WB,
        ST_FILT_MUL,
        ST_FILT_WB,
        ST_MIX,
        ST_FMT_MUL,
        ST_FMT_WB
    } state_t;

    typedef enum logic [1:0] {
        MUL_TONE,
        MUL_NOISE,
        MUL_FILT,
        MUL_FMT
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     div_step_b;
        logic     cap_num;
        logic     phase_upd;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     wb_tone;
        logic     wb_noise;
        logic     wb_filt;
        logic     wb_mix;
        logic     wb_code;
    } cmd_t;

    typedef struct packed {
        logic silent;
        logic bypass;
    } sts_t;

    // first-quadrant sine magnitude in the mix format, taylor series to x^13 in q30
    function automatic logic [SINE_MAG_W-1:0] sine_quarter(input int unsigned r);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        x    = (64'(r) * HALF_PI_Q30) >> QIDX_W;
        term = x;
        sum  = longint'(x);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        v = (sum < 0) ? 64'd0 : 64'(sum);
        v = (v + (64'd1 << (29 - MIX_FRAC_BITS))) >> (30 - MIX_FRAC_BITS);
        if (v > 64'(SINE_ONE))
        begin
            v = 64'(SINE_ONE);
        end
        return v[SINE_MAG_W-1:0];
    endfunction

endpackage

/* rtl/tnsg_ctrl.sv */
module tnsg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tnsg_pkg::sts_t    sts,
    output tnsg_pkg::cmd_t    cmd
);

    tnsg_pkg::state_t             state_reg;
    tnsg_pkg::state_t             state_next;
    logic [tnsg_pkg::CNT_W-1:0]   cnt_reg;
    logic [tnsg_pkg::CNT_W-1:0]   cnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         slot_free;
    logic                         last_step;

    assign slot_free = !out_valid_reg || out_ready;
    assign last_step = (cnt_reg == tnsg_pkg::CNT_W'(tnsg_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tnsg_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tnsg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tnsg_pkg::ST_DIV;
                end
            end
            tnsg_pkg::ST_DIV:
            begin
                if (sts.silent)
                begin
                    state_next = tnsg_pkg::ST_NOISE_MUL;
                end
                else if (last_step)
                begin
                    state_next = tnsg_pkg::ST_PHASE;
                end
            end
            tnsg_pkg::ST_PHASE:     state_next = tnsg_pkg::ST_TONE_MUL;
            tnsg_pkg::ST_TONE_MUL:  state_next = tnsg_pkg::ST_TONE_WB;
            tnsg_pkg::ST_TONE_WB:   state_next = tnsg_pkg::ST_NOISE_MUL;
            tnsg_pkg::ST_NOISE_MUL: state_next = tnsg_pkg::ST_NOISE_WB;
            tnsg_pkg::ST_NOISE_WB:
            begin
                state_next = sts.bypass ? tnsg_pkg::ST_MIX : tnsg_pkg::ST_FILT_MUL;
            end
            tnsg_pkg::ST_FILT_MUL:  state_next = tnsg_pkg::ST_FILT_WB;
            tnsg_pkg::ST_FILT_WB:   state_next = tnsg_pkg::ST_MIX;
            tnsg_pkg::ST_MIX:       state_next = tnsg_pkg::ST_FMT_MUL;
            tnsg_pkg::ST_FMT_MUL:   state_next = tnsg_pkg::ST_FMT_WB;
            tnsg_pkg::ST_FMT_WB:
            begin
                if (slot_free)
                begin
                    state_next = tnsg_pkg::ST_IDLE;
                end
            end
            default:                state_next = tnsg_pkg::ST_IDLE;
        endcase
    end

    // divider step count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == tnsg_pkg::ST_IDLE)
        begin
            cnt_next = '0;
        end
        else if (state_reg == tnsg_pkg::ST_DIV && !sts.silent && !last_step)
        begin
            cnt_next = cnt_reg + tnsg_pkg::CNT_W'(1);
        end
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = tnsg_pkg::MUL_TONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            tnsg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tnsg_pkg::ST_DIV:
            begin
                cmd.div_step   = !sts.silent;
                cmd.div_step_b = !sts.silent && (cnt_reg < tnsg_pkg::CNT_W'(tnsg_pkg::FREQ_W));
                cmd.cap_num    = !sts.silent && (cnt_reg == tnsg_pkg::CNT_W'(tnsg_pkg::RATE_W));
            end
            tnsg_pkg::ST_PHASE:     cmd.phase_upd = 1'b1;
            tnsg_pkg::ST_TONE_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tnsg_pkg::MUL_TONE;
            end
            tnsg_pkg::ST_TONE_WB:   cmd.wb_tone = 1'b1;
            tnsg_pkg::ST_NOISE_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tnsg_pkg::MUL_NOISE;
            end
            tnsg_pkg::ST_NOISE_WB:  cmd.wb_noise = 1'b1;
            tnsg_pkg::ST_FILT_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tnsg_pkg::MUL_FILT;
            end
            tnsg_pkg::ST_FILT_WB:   cmd.wb_filt = 1'b1;
            tnsg_pkg::ST_MIX:       cmd.wb_mix = 1'b1;
            tnsg_pkg::ST_FMT_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tnsg_pkg::MUL_FMT;
            end
            tnsg_pkg::ST_FMT_WB:
            begin
                cmd.wb_code = slot_free;
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/tnsg_dp.sv */
module tnsg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tnsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tnsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                segment_start,
    input  logic                                silent,
    input  logic [tnsg_pkg::DRAW_W-1:0]         noise_draw,
    input  tnsg_pkg::cmd_t                      cmd,
    output tnsg_pkg::sts_t                      sts,
    output logic [tnsg_pkg::CODE_W-1:0]         sample_code
);

    localparam int RW = tnsg_pkg::RATE_W;
    localparam int FW = tnsg_pkg::FREQ_W;
    localparam int MW = tnsg_pkg::MIX_W;
    localparam int UW = tnsg_pkg::MUL_W;
    localparam int DW = tnsg_pkg::DRAW_W;
    localparam int CW = tnsg_pkg::CODE_W;
    localparam int TB = tnsg_pkg::SINE_TABLE_BITS;
    localparam int QW = tnsg_pkg::QIDX_W;
    localparam logic signed [MW:0] MIX_HI = $signed({1'b0, tnsg_pkg::MIX_ONE});
    localparam logic signed [MW:0] MIX_LO = -MIX_HI;
    localparam logic [DW:0]        DRAW_MID2 = (DW + 1)'(1) << DW;

    // configuration
    logic [FW-1:0]                       freq_reg;
    logic [RW-1:0]                       rate_reg;
    logic [tnsg_pkg::LEVEL_W-1:0]        level_reg;
    logic [tnsg_pkg::GAIN_W-1:0]         gain_reg;
    logic [tnsg_pkg::FMT_W-1:0]          fmt_reg;

    // state
    logic [RW-1:0]                       phase_reg;
    logic signed [MW-1:0]                filt_reg;
    logic                                silent_reg;

    // request payload and working registers
    logic [DW-1:0]                       draw_reg;
    logic [tnsg_pkg::DIV_STEPS-1:0]      dvd_a_reg;
    logic [RW-1:0]                       rem_a_reg;
    logic [TB-1:0]                       quo_reg;
    logic [FW-1:0]                       dvd_b_reg;
    logic [RW-1:0]                       rem_b_reg;
    logic [RW-1:0]                       num_reg;
    logic [tnsg_pkg::SINE_MAG_W-1:0]     tone_mag_reg;
    logic                                tone_neg_reg;
    logic [tnsg_pkg::PROD_W-1:0]         prod_reg;
    logic                                prod_neg_reg;
    logic signed [MW-1:0]                w_reg;
    logic signed [MW-1:0]                n_reg;
    logic signed [MW-1:0]                m_reg;
    logic [CW-1:0]                       code_reg;

    logic [RW-1:0]                       rate_eff;
    logic [tnsg_pkg::LEVEL_W-1:0]        level_eff;
    logic [RW:0]                         rem_a_sh;
    logic [RW:0]                         rem_a_sub;
    logic                                ge_a;
    logic [RW:0]                         rem_b_sh;
    logic [RW:0]                         rem_b_sub;
    logic                                ge_b;
    logic [RW:0]                         phase_sum;
    logic [RW:0]                         phase_sub;
    logic [1:0]                          quad;
    logic [QW:0]                         r_fold;
    logic [tnsg_pkg::SINE_MAG_W-1:0]     sine_rom [tnsg_pkg::QUARTER];
    logic [tnsg_pkg::SINE_MAG_W-1:0]     sine_mag;
    logic [DW:0]                         draw2;
    logic [DW:0]                         s_mag;
    logic signed [MW:0]                  diff;
    logic [MW:0]                         diff_abs;
    logic [MW-1:0]                       m_abs;
    logic [MW-1:0]                       one_plus_m;
    logic [UW-1:0]                       mul_a;
    logic [UW-1:0]                       mul_b;
    logic                                mul_neg;
    logic [MW-1:0]                       scaled;
    logic signed [MW:0]                  gval;
    logic signed [MW:0]                  filt_sum;
    logic signed [MW:0]                  mix_sum;
    logic signed [MW-1:0]                mix_clamped;
    logic [CW-1:0]                       uv;
    logic [CW-1:0]                       sv_mag;
    logic [CW-1:0]                       sv;
    logic [CW-1:0]                       code_next;

    for (genvar gi = 0; gi < tnsg_pkg::QUARTER; gi++)
    begin : g_sine
        assign sine_rom[gi] = tnsg_pkg::sine_quarter(gi);
    end

    assign rate_eff  = (rate_reg == '0) ? RW'(1) : rate_reg;
    assign level_eff = (level_reg > tnsg_pkg::GAIN_ONE) ? tnsg_pkg::GAIN_ONE : level_reg;

    assign sts.silent = silent_reg;
    assign sts.bypass = (gain_reg >= tnsg_pkg::GAIN_ONE);

    // restoring divider, phase lane and frequency lane
    assign rem_a_sh  = {rem_a_reg, dvd_a_reg[tnsg_pkg::DIV_STEPS-1]};
    assign rem_a_sub = rem_a_sh - {1'b0, rate_eff};
    assign ge_a      = (rem_a_sh >= {1'b0, rate_eff});
    assign rem_b_sh  = {rem_b_reg, dvd_b_reg[FW-1]};
    assign rem_b_sub = rem_b_sh - {1'b0, rate_eff};
    assign ge_b      = (rem_b_sh >= {1'b0, rate_eff});

    assign phase_sum = {1'b0, num_reg} + {1'b0, rem_b_reg};
    assign phase_sub = phase_sum - {1'b0, rate_eff};

    // full-cycle index folded onto the quarter table
    assign quad     = quo_reg[TB-1 -: 2];
    assign r_fold   = quad[0] ? ((QW + 1)'(tnsg_pkg::QUARTER) - {1'b0, quo_reg[QW-1:0]})
                              : {1'b0, quo_reg[QW-1:0]};
    assign sine_mag = r_fold[QW] ? tnsg_pkg::SINE_ONE : sine_rom[r_fold[QW-1:0]];

    // noise draw mapped to a signed magnitude
    assign draw2 = {draw_reg, 1'b0};
    assign s_mag = draw_reg[DW-1] ? (draw2 - DRAW_MID2) : (DRAW_MID2 - draw2);

    assign diff       = {n_reg[MW-1], n_reg} - {filt_reg[MW-1], filt_reg};
    assign diff_abs   = diff[MW] ? (MW + 1)'(-diff) : (MW + 1)'(diff);
    assign m_abs      = m_reg[MW-1] ? MW'(-m_reg) : MW'(m_reg);
    assign one_plus_m = tnsg_pkg::MIX_ONE + MW'(m_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.mul_sel)
            tnsg_pkg::MUL_TONE:
            begin
                mul_a   = UW'(tone_mag_reg);
                mul_b   = UW'(tnsg_pkg::GAIN_ONE - level_eff);
                mul_neg = tone_neg_reg;
            end
            tnsg_pkg::MUL_NOISE:
            begin
                mul_a   = UW'(s_mag >> tnsg_pkg::NOISE_SHIFT);
                mul_b   = UW'(level_eff);
                mul_neg = !draw_reg[DW-1];
            end
            tnsg_pkg::MUL_FILT:
            begin
                mul_a   = UW'(diff_abs);
                mul_b   = UW'(gain_reg);
                mul_neg = diff[MW];
            end
            tnsg_pkg::MUL_FMT:
            begin
                case (fmt_reg)
                    tnsg_pkg::FMT_U8:
                    begin
                        mul_a = UW'(one_plus_m);
                        mul_b = tnsg_pkg::MAX_U8;
                    end
                    tnsg_pkg::FMT_S8:
                    begin
                        mul_a   = UW'(m_abs);
                        mul_b   = tnsg_pkg::MAX_S8;
                        mul_neg = m_reg[MW-1];
                    end
                    tnsg_pkg::FMT_U16:
                    begin
                        mul_a = UW'(one_plus_m);
                        mul_b = tnsg_pkg::MAX_U16;
                    end
                    tnsg_pkg::FMT_S16:
                    begin
                        mul_a   = UW'(m_abs);
                        mul_b   = tnsg_pkg::MAX_S16;
                        mul_neg = m_reg[MW-1];
                    end
                    tnsg_pkg::FMT_U24:
                    begin
                        mul_a = UW'(one_plus_m);
                        mul_b = tnsg_pkg::MAX_U24;
                    end
                    tnsg_pkg::FMT_S24:
                    begin
                        mul_a   = UW'(m_abs);
                        mul_b   = tnsg_pkg::MAX_S24;
                        mul_neg = m_reg[MW-1];
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product back to a signed mix value
    assign scaled   = prod_reg[tnsg_pkg::GAIN_SHIFT +: MW];
    assign gval     = prod_neg_reg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
    assign filt_sum = {filt_reg[MW-1], filt_reg} + gval;
    assign mix_sum  = {w_reg[MW-1], w_reg} + {n_reg[MW-1], n_reg};

    always_comb
    begin
        if (mix_sum > MIX_HI)
        begin
            mix_clamped = MW'(MIX_HI);
        end
        else if (mix_sum < MIX_LO)
        begin
            mix_clamped = MW'(MIX_LO);
        end
        else
        begin
            mix_clamped = mix_sum[MW-1:0];
        end
    end

    // quantizer
    assign uv     = prod_reg[tnsg_pkg::MIX_FRAC_BITS + 1 +: CW];
    assign sv_mag = prod_reg[tnsg_pkg::MIX_FRAC_BITS +: CW];
    assign sv     = prod_neg_reg ? (CW'(0) - sv_mag) : sv_mag;

    always_comb
    begin
        case (fmt_reg)
            tnsg_pkg::FMT_U8:  code_next = uv;
            tnsg_pkg::FMT_U16: code_next = uv;
            tnsg_pkg::FMT_U24: code_next = uv;
            tnsg_pkg::FMT_S8:  code_next = CW'(sv[7:0]);
            tnsg_pkg::FMT_S16: code_next = CW'(sv[15:0]);
            tnsg_pkg::FMT_S24: code_next = sv;
            default:           code_next = '0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= tnsg_pkg::FREQ_RST;
            rate_reg   <= tnsg_pkg::RATE_RST;
            level_reg  <= tnsg_pkg::LEVEL_RST;
            gain_reg   <= tnsg_pkg::GAIN_RST;
            fmt_reg    <= tnsg_pkg::FMT_RST;
            phase_reg  <= '0;
            filt_reg   <= '0;
            silent_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tnsg_pkg::CFG_TONE_FREQUENCY: freq_reg  <= cfg_data[FW-1:0];
                    tnsg_pkg::CFG_SAMPLE_RATE:    rate_reg  <= cfg_data[RW-1:0];
                    tnsg_pkg::CFG_NOISE_LEVEL:    level_reg <= cfg_data[tnsg_pkg::LEVEL_W-1:0];
                    tnsg_pkg::CFG_FILTER_GAIN:    gain_reg  <= cfg_data[tnsg_pkg::GAIN_W-1:0];
                    tnsg_pkg::CFG_SAMPLE_FORMAT:  fmt_reg   <= cfg_data[tnsg_pkg::FMT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load)
            begin
                silent_reg <= silent;
                if (segment_start)
                begin
                    phase_reg <= '0;
                    filt_reg  <= '0;
                end
            end
            if (cmd.phase_upd)
            begin
                phase_reg <= (phase_sum >= {1'b0, rate_eff}) ? phase_sub[RW-1:0]
                                                              : phase_sum[RW-1:0];
            end
            if (cmd.wb_filt)
            begin
                filt_reg <= filt_sum[MW-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            draw_reg  <= noise_draw;
            dvd_a_reg <= {(segment_start ? RW'(0) : phase_reg), TB'(0)};
            rem_a_reg <= '0;
            dvd_b_reg <= freq_reg;
            rem_b_reg <= '0;
            w_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_a_reg <= {dvd_a_reg[tnsg_pkg::DIV_STEPS-2:0], 1'b0};
            rem_a_reg <= ge_a ? rem_a_sub[RW-1:0] : rem_a_sh[RW-1:0];
            quo_reg   <= {quo_reg[TB-2:0], ge_a};
        end
        if (cmd.div_step_b)
        begin
            dvd_b_reg <= {dvd_b_reg[FW-2:0], 1'b0};
            rem_b_reg <= ge_b ? rem_b_sub[RW-1:0] : rem_b_sh[RW-1:0];
        end
        if (cmd.cap_num)
        begin
            num_reg <= rem_a_reg;
        end
        if (cmd.phase_upd)
        begin
            tone_mag_reg <= sine_mag;
            tone_neg_reg <= quad[1];
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= mul_a * mul_b;
            prod_neg_reg <= mul_neg;
        end
        if (cmd.wb_tone)
        begin
            w_reg <= gval[MW-1:0];
        end
        if (cmd.wb_noise)
        begin
            n_reg <= gval[MW-1:0];
        end
        if (cmd.wb_filt)
        begin
            n_reg <= filt_sum[MW-1:0];
        end
        if (cmd.wb_mix)
        begin
            m_reg <= mix_clamped;
        end
        if (cmd.wb_code)
        begin
            code_reg <= code_next;
        end
    end

    assign sample_code = code_reg;

endmodule

/* rtl/tone_noise_sample_generator_top.sv */
// tone plus filtered noise audio sample generator
// input channel: in_valid/in_ready with segment_start, silent and noise_draw;
// each request yields exactly one sample_code on the out_valid/out_ready channel.
// configuration: cfg_wr_en writes cfg_data into register cfg_index at the clock edge
// (0 tone_frequency, 1 sample_rate, 2 noise_level, 3 filter_gain, 4 sample_format);
// write only while no request is in flight.
// a tonal request runs a 28-step restoring divide of the phase by the sample rate,
// then up to four products through one shared 24x24 multiplier, the filter product
// only when the low-pass filter is active.
// a silent request skips the divide and the tone product.
// a new request is accepted the cycle after the previous result is registered.
// the result sits in an output register; if the receiver stalls, the next request
// runs up to its last step and waits there for the register to empty.
// reset loads the register defaults (900 Hz, 48000 Hz, no noise, filter bypassed,
// signed 16-bit) and clears the phase and the filter memory.
module tone_noise_sample_generator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tnsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tnsg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             segment_start,
    input  logic                             silent,
    input  logic [tnsg_pkg::DRAW_W-1:0]      noise_draw,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tnsg_pkg::CODE_W-1:0]      sample_code
);

    tnsg_pkg::cmd_t cmd;
    tnsg_pkg::sts_t sts;

    tnsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tnsg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .segment_start (segment_start),
        .silent        (silent),
        .noise_draw    (noise_draw),
        .cmd           (cmd),
        .sts           (sts),
        .sample_code   (sample_code)
    );

endmodule

/* sim/tone_noise_sample_generator_top_test.sv */
module tone_noise_sample_generator_top_test;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     DRAIN_CYCLES   = 60;
    localparam int     ROM_SIZE       = 1 << tnsg_pkg::SINE_TABLE_BITS;
    localparam longint FULL_SCALE     = longint'(1) << tnsg_pkg::MIX_FRAC_BITS;
    localparam longint UNITY_GAIN     = longint'(tnsg_pkg::GAIN_ONE);

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [tnsg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tnsg_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic                            segment_start;
    logic                            silent;
    logic [tnsg_pkg::DRAW_W-1:0]     noise_draw;
    logic                            out_valid;
    logic                            out_ready;
    logic [tnsg_pkg::CODE_W-1:0]     sample_code;

    // predictor copy of the registers and the state
    logic [tnsg_pkg::FREQ_W-1:0]     tone_freq;
    logic [tnsg_pkg::RATE_W-1:0]     rate_reg;
    logic [tnsg_pkg::LEVEL_W-1:0]    level_reg;
    logic [tnsg_pkg::GAIN_W-1:0]     gain_reg;
    logic [tnsg_pkg::FMT_W-1:0]      format_reg;
    longint                          tone_phase;
    longint                          noise_memory;
    longint                          sine_rom [0:ROM_SIZE-1];

    logic [tnsg_pkg::CODE_W-1:0]     expected_codes [$];
    logic [tnsg_pkg::CODE_W-1:0]     wanted_code;
    int                              error_count;
    int                              idle_cycles;
    bit                              hold_output;
    bit                              no_idle;

    tone_noise_sample_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .segment_start (segment_start),
        .silent        (silent),
        .noise_draw    (noise_draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_code   (sample_code)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint scale_toward_zero(longint v, longint g, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag * g) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint sine_value(int unsigned i);
        int unsigned quad;
        int unsigned r;
        int          k;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        longint      acc;
        quad = i >> (tnsg_pkg::SINE_TABLE_BITS - 2);
        r    = i & ((1 << (tnsg_pkg::SINE_TABLE_BITS - 2)) - 1);
        if ((quad & 1) != 0)
        begin
            r = (1 << (tnsg_pkg::SINE_TABLE_BITS - 2)) - r;
        end
        x    = (64'(r) * tnsg_pkg::HALF_PI_Q30) >> (tnsg_pkg::SINE_TABLE_BITS - 2);
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 6; k++)
        begin
            term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        v = (acc < 0) ? 64'd0 : 64'(acc);
        v = (v + (64'd1 << (29 - tnsg_pkg::MIX_FRAC_BITS))) >> (30 - tnsg_pkg::MIX_FRAC_BITS);
        if (v > 64'(FULL_SCALE))
        begin
            v = 64'(FULL_SCALE);
        end
        return (quad >= 2) ? -longint'(v) : longint'(v);
    endfunction

    function automatic logic [tnsg_pkg::CODE_W-1:0] predict_sample(
        logic seg, logic sil, logic [tnsg_pkg::DRAW_W-1:0] draw);
        longint rate;
        longint level;
        longint num;
        longint idx;
        longint tone;
        longint noise;
        longint mix;
        longint code;
        rate  = (rate_reg == 0) ? 1 : longint'(rate_reg);
        level = (longint'(level_reg) > UNITY_GAIN) ? UNITY_GAIN : longint'(level_reg);
        tone  = 0;
        if (seg)
        begin
            tone_phase   = 0;
            noise_memory = 0;
        end
        if (!sil)
        begin
            num        = tone_phase % rate;
            idx        = (num << tnsg_pkg::SINE_TABLE_BITS) / rate;
            tone       = scale_toward_zero(sine_rom[idx], UNITY_GAIN - level,
                                           tnsg_pkg::GAIN_SHIFT);
            tone_phase = (num + longint'(tone_freq) % rate) % rate;
        end
        noise = 2 * longint'(draw) - (longint'(1) << tnsg_pkg::DRAW_W);
        noise = scale_toward_zero(noise, 1, tnsg_pkg::DRAW_W - tnsg_pkg::MIX_FRAC_BITS);
        noise = scale_toward_zero(noise, level, tnsg_pkg::GAIN_SHIFT);
        if (longint'(gain_reg) < UNITY_GAIN)
        begin
            noise = noise_memory
                  + scale_toward_zero(noise - noise_memory, longint'(gain_reg),
                                      tnsg_pkg::GAIN_SHIFT);
            noise_memory = noise;
        end
        mix = tone + noise;
        if (mix > FULL_SCALE)
        begin
            mix = FULL_SCALE;
        end
        if (mix < -FULL_SCALE)
        begin
            mix = -FULL_SCALE;
        end
        case (format_reg)
            tnsg_pkg::FMT_U8:
                code = ((FULL_SCALE + mix) * longint'(tnsg_pkg::MAX_U8)) / (FULL_SCALE * 2);
            tnsg_pkg::FMT_S8:
                code = scale_toward_zero(mix, longint'(tnsg_pkg::MAX_S8),
                                         tnsg_pkg::MIX_FRAC_BITS) & 'hFF;
            tnsg_pkg::FMT_U16:
                code = ((FULL_SCALE + mix) * longint'(tnsg_pkg::MAX_U16)) / (FULL_SCALE * 2);
            tnsg_pkg::FMT_S16:
                code = scale_toward_zero(mix, longint'(tnsg_pkg::MAX_S16),
                                         tnsg_pkg::MIX_FRAC_BITS) & 'hFFFF;
            tnsg_pkg::FMT_U24:
                code = ((FULL_SCALE + mix) * longint'(tnsg_pkg::MAX_U24)) / (FULL_SCALE * 2);
            tnsg_pkg::FMT_S24:
                code = scale_toward_zero(mix, longint'(tnsg_pkg::MAX_S24),
                                         tnsg_pkg::MIX_FRAC_BITS) & 'hFFFFFF;
            default: code = 0;
        endcase
        return code[tnsg_pkg::CODE_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 16);
        end
        return $urandom_range(20, 150);
    endfunction

    task automatic write_register(logic [tnsg_pkg::CFG_IDX_W-1:0] index,
                                  logic [tnsg_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            tnsg_pkg::CFG_TONE_FREQUENCY: tone_freq  = value[tnsg_pkg::FREQ_W-1:0];
            tnsg_pkg::CFG_SAMPLE_RATE:    rate_reg   = value[tnsg_pkg::RATE_W-1:0];
            tnsg_pkg::CFG_NOISE_LEVEL:    level_reg  = value[tnsg_pkg::LEVEL_W-1:0];
            tnsg_pkg::CFG_FILTER_GAIN:    gain_reg   = value[tnsg_pkg::GAIN_W-1:0];
            tnsg_pkg::CFG_SAMPLE_FORMAT:  format_reg = value[tnsg_pkg::FMT_W-1:0];
            default:                      ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_request(logic seg, logic sil, logic [tnsg_pkg::DRAW_W-1:0] draw,
                                int gap);
        in_valid      <= 1'b1;
        segment_start <= seg;
        silent        <= sil;
        noise_draw    <= draw;
        do
            @(posedge clk);
        while (!in_ready);
        expected_codes.push_back(predict_sample(seg, sil, draw));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_request(int gap);
        logic [tnsg_pkg::DRAW_W-1:0] draw;
        int                          r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            draw = '0;
        end
        else if (r < 12)
        begin
            draw = '1;
        end
        else
        begin
            draw = tnsg_pkg::DRAW_W'($urandom);
        end
        send_request($urandom_range(0, 99) < 4, $urandom_range(0, 99) < 15, draw, gap);
    endtask

    task automatic test_reset_defaults();
        send_request(1'b1, 1'b0, 24'h000000, pick_gap());
        send_request(1'b0, 1'b0, 24'hFFFFFF, pick_gap());
        send_request(1'b0, 1'b1, 24'h800000, pick_gap());
        send_request(1'b0, 1'b0, 24'h7FFFFF, pick_gap());
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        int f;
        // every format, including the two unknown codes
        write_register(tnsg_pkg::CFG_NOISE_LEVEL, 18'd32768);
        write_register(tnsg_pkg::CFG_FILTER_GAIN, 18'd65536);
        for (f = 0; f < 8; f++)
        begin
            write_register(tnsg_pkg::CFG_SAMPLE_FORMAT, tnsg_pkg::CFG_DATA_W'(f));
            send_request(1'b0, f == 2, (f % 2 == 1) ? 24'hFFFFFF : 24'h000000, pick_gap());
            wait_drained();
        end
        // noise level beyond full scale
        write_register(tnsg_pkg::CFG_NOISE_LEVEL, 18'h3FFFF);
        write_register(tnsg_pkg::CFG_SAMPLE_FORMAT, tnsg_pkg::CFG_DATA_W'(tnsg_pkg::FMT_S24));
        send_request(1'b0, 1'b0, 24'hFFFFFF, pick_gap());
        send_request(1'b1, 1'b1, 24'h000000, pick_gap());
        wait_drained();
        // filter gain zero, minimum, just below and above bypass
        write_register(tnsg_pkg::CFG_NOISE_LEVEL, 18'd65536);
        write_register(tnsg_pkg::CFG_FILTER_GAIN, 18'd0);
        send_request(1'b0, 1'b1, 24'hFFFFFF, pick_gap());
        wait_drained();
        write_register(tnsg_pkg::CFG_FILTER_GAIN, 18'd1);
        send_request(1'b0, 1'b1, 24'hFFFFFF, pick_gap());
        wait_drained();
        write_register(tnsg_pkg::CFG_FILTER_GAIN, 18'd65535);
        send_request(1'b0, 1'b1, 24'h000000, pick_gap());
        wait_drained();
        write_register(tnsg_pkg::CFG_FILTER_GAIN, 18'h1FFFF);
        send_request(1'b0, 1'b0, 24'h000000, pick_gap());
        wait_drained();
        // zero rate, frequency above rate
        write_register(tnsg_pkg::CFG_NOISE_LEVEL, 18'd0);
        write_register(tnsg_pkg::CFG_FILTER_GAIN, 18'd65536);
        write_register(tnsg_pkg::CFG_SAMPLE_FORMAT, tnsg_pkg::CFG_DATA_W'(tnsg_pkg::FMT_U24));
        write_register(tnsg_pkg::CFG_SAMPLE_RATE, 18'd0);
        write_register(tnsg_pkg::CFG_TONE_FREQUENCY, 18'd65535);
        send_request(1'b0, 1'b0, 24'h123456, pick_gap());
        wait_drained();
        // phase left above a lowered rate
        write_register(tnsg_pkg::CFG_SAMPLE_RATE, 18'h3FFFF);
        write_register(tnsg_pkg::CFG_TONE_FREQUENCY, 18'd60000);
        send_request(1'b1, 1'b0, 24'h000001, pick_gap());
        send_request(1'b0, 1'b0, 24'hFFFFFE, pick_gap());
        send_request(1'b0, 1'b0, 24'h555555, pick_gap());
        send_request(1'b0, 1'b0, 24'hAAAAAA, pick_gap());
        wait_drained();
        write_register(tnsg_pkg::CFG_SAMPLE_RATE, 18'd1000);
        send_request(1'b0, 1'b0, 24'h000000, pick_gap());
        wait_drained();
        write_register(tnsg_pkg::CFG_SAMPLE_RATE, 18'd48000);
        send_request(1'b0, 1'b0, 24'hFFFFFF, pick_gap());
        wait_drained();
    endtask

    task automatic randomize_settings();
        logic [tnsg_pkg::CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 18'd0;
            1:       v = 18'd1;
            2:       v = 18'h3FFFF;
            3:       v = 18'd192000;
            4:       v = 18'd8000;
            5:       v = 18'd44100;
            6:       v = 18'd48000;
            default: v = tnsg_pkg::CFG_DATA_W'($urandom_range(2, 200000));
        endcase
        write_register(tnsg_pkg::CFG_SAMPLE_RATE, v);
        case ($urandom_range(0, 5))
            0:       v = 18'd0;
            1:       v = 18'd65535;
            2:       v = tnsg_pkg::CFG_DATA_W'($urandom_range(1, 2000));
            default: v = tnsg_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        endcase
        write_register(tnsg_pkg::CFG_TONE_FREQUENCY, v);
        case ($urandom_range(0, 5))
            0:       v = 18'd0;
            1:       v = 18'd65536;
            2:       v = tnsg_pkg::CFG_DATA_W'($urandom_range(65537, 262143));
            default: v = tnsg_pkg::CFG_DATA_W'($urandom_range(0, 65536));
        endcase
        write_register(tnsg_pkg::CFG_NOISE_LEVEL, v);
        case ($urandom_range(0, 7))
            0:       v = 18'd0;
            1:       v = 18'd1;
            2:       v = 18'd65535;
            3:       v = 18'd65536;
            4:       v = tnsg_pkg::CFG_DATA_W'($urandom_range(65537, 262143));
            default: v = tnsg_pkg::CFG_DATA_W'($urandom_range(1, 65535));
        endcase
        write_register(tnsg_pkg::CFG_FILTER_GAIN, v);
        if ($urandom_range(0, 9) == 0)
        begin
            v = tnsg_pkg::CFG_DATA_W'($urandom_range(6, 7));
        end
        else
        begin
            v = tnsg_pkg::CFG_DATA_W'($urandom_range(0, 5));
        end
        write_register(tnsg_pkg::CFG_SAMPLE_FORMAT, v);
    endtask

    task automatic test_random_settings();
        int p;
        int i;
        for (p = 0; p < 13; p++)
        begin
            randomize_settings();
            no_idle = (p % 4 == 3);
            for (i = 0; i < 100; i++)
            begin
                send_random_request(pick_gap());
            end
            wait_drained();
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        int i;
        write_register(tnsg_pkg::CFG_SAMPLE_RATE, 18'd48000);
        write_register(tnsg_pkg::CFG_NOISE_LEVEL, 18'd20000);
        write_register(tnsg_pkg::CFG_FILTER_GAIN, 18'd3000);
        write_register(tnsg_pkg::CFG_SAMPLE_FORMAT, tnsg_pkg::CFG_DATA_W'(tnsg_pkg::FMT_S16));
        hold_output = 1'b1;
        for (i = 0; i < 24; i++)
        begin
            send_random_request(0);
        end
        wait_drained();
    endtask

    // receiver side
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_output)
            begin
                out_ready   <= 1'b0;
                hold_output  = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                gap = pick_gap();
                if (gap != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                    begin
                        $display("unexpected sample_code %06h", sample_code);
                    end
                end
                else
                begin
                    wanted_code = expected_codes.pop_front();
                    if (sample_code !== wanted_code)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= 10)
                        begin
                            $display("sample_code mismatch: expected %06h got %06h",
                                     wanted_code, sample_code);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int i;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        segment_start <= 1'b0;
        silent        <= 1'b0;
        noise_draw    <= '0;
        error_count    = 0;
        idle_cycles    = 0;
        hold_output    = 1'b0;
        no_idle        = 1'b0;
        tone_freq      = tnsg_pkg::FREQ_RST;
        rate_reg       = tnsg_pkg::RATE_RST;
        level_reg      = tnsg_pkg::LEVEL_RST;
        gain_reg       = tnsg_pkg::GAIN_RST;
        format_reg     = tnsg_pkg::FMT_RST;
        tone_phase     = 0;
        noise_memory   = 0;
        for (i = 0; i < ROM_SIZE; i++)
        begin
            sine_rom[i] = sine_value(i);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_extremes();
        test_random_settings();
        test_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_codes.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tnsg_pkg.sv
rtl/tnsg_ctrl.sv
rtl/tnsg_dp.sv
rtl/tone_noise_sample_generator_top.sv
sim/tone_noise_sample_generator_top_test.sv
